// File: rtl/ghbp_pkg.sv
// ----------------------------------------------------------------------------
// ghbp_pkg
// Shared types, constants and the counter update rule for the global history
// branch predictor.
// ----------------------------------------------------------------------------
package ghbp_pkg;

  // Width of a branch address on the request channel.
  localparam int unsigned PC_W = 32;

  // Default table geometry.
  localparam int unsigned DEF_PC_INDEX_BITS = 10;
  localparam int unsigned DEF_HISTORY_BITS  = 4;

  // Two-bit saturating counter.
  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_STRONG_NT = 2'd0;
  localparam ctr_t CTR_WEAK_NT   = 2'd1;
  localparam ctr_t CTR_WEAK_T    = 2'd2;
  localparam ctr_t CTR_STRONG_T  = 2'd3;

  // Every table entry starts as strongly taken.
  localparam ctr_t CTR_RESET = CTR_STRONG_T;

  // Hysteresis update: a weak state jumps to the strong state of the outcome,
  // while a strong state against the outcome only steps to its weak state.
  function automatic ctr_t next_count(input ctr_t c, input logic taken);
    ctr_t n;
    n = CTR_STRONG_NT;
    if (taken) begin
      case (c)
        CTR_STRONG_NT: n = CTR_WEAK_NT;
        default:       n = CTR_STRONG_T;
      endcase
    end else begin
      case (c)
        CTR_STRONG_T: n = CTR_WEAK_T;
        default:      n = CTR_STRONG_NT;
      endcase
    end
    return n;
  endfunction

  // A counter of weakly or strongly taken predicts taken.
  function automatic logic predicts_taken(input ctr_t c);
    return (c == CTR_WEAK_T) || (c == CTR_STRONG_T);
  endfunction

endpackage

// File: rtl/ghbp_if.sv
// ----------------------------------------------------------------------------
// ghbp_if
// Request and result channel interfaces of the global history branch
// predictor, each with valid/ready handshaking.
// ----------------------------------------------------------------------------

// Request channel: one resolved branch.
interface ghbp_in_if;
  logic                      valid;
  logic                      ready;
  logic [ghbp_pkg::PC_W-1:0] branch_pc;
  logic                      branch_taken;

  modport source (output valid, output branch_pc, output branch_taken, input ready);
  modport sink   (input valid, input branch_pc, input branch_taken, output ready);
endinterface

// Result channel: the prediction made for that branch.
interface ghbp_out_if;
  logic valid;
  logic ready;
  logic predict_taken;

  modport source (output valid, output predict_taken, input ready);
  modport sink   (input valid, input predict_taken, output ready);
endinterface

// File: rtl/global_history_branch_predictor.sv
// ----------------------------------------------------------------------------
// global_history_branch_predictor
// Gselect predictor with two-bit hysteresis counters held in one synchronous
// memory, indexed by the global history above the low branch address bits.
// ----------------------------------------------------------------------------
// Usage: after reset the block sweeps all 2^(HISTORY_BITS+PC_INDEX_BITS)
// entries of its counter memory (16384 at the default geometry), writing one
// entry per cycle, and in_chan.ready stays low until the sweep is done. From
// then on it takes one request per clock while results are taken. Each
// request reads the memory at the accepting edge. When the update stage
// advances, its counter is updated and written back, and its prediction is
// loaded into the output register at that same edge. The memory has a single
// write port and a registered read; a request hitting the entry that the
// previous request is writing back sees the new value through a forwarding
// register, so back-to-back branches to the same entry cost nothing. A
// stalled result holds the update stage and with it the request channel.
// ----------------------------------------------------------------------------
module global_history_branch_predictor #(
  parameter int unsigned PC_INDEX_BITS = ghbp_pkg::DEF_PC_INDEX_BITS,
  parameter int unsigned HISTORY_BITS  = ghbp_pkg::DEF_HISTORY_BITS
) (
  input logic        clk,
  input logic        rst_n,
  ghbp_in_if.sink    in_chan,
  ghbp_out_if.source out_chan
);
  import ghbp_pkg::*;

  localparam int unsigned TABLE_BITS  = PC_INDEX_BITS + HISTORY_BITS;
  localparam int unsigned TABLE_DEPTH = 1 << TABLE_BITS;

  typedef logic [TABLE_BITS-1:0] idx_t;

  // Counter memory.
  ctr_t mem [TABLE_DEPTH];

  // Control and data registers.
  logic [HISTORY_BITS-1:0] hist_r;
  logic                    init_done_r;
  idx_t                    clr_idx_r;
  logic                    s1_valid_r;
  idx_t                    s1_idx_r;
  logic                    s1_taken_r;
  ctr_t                    rd_data_r;
  logic                    fwd_valid_r;
  idx_t                    wr_idx_r;
  ctr_t                    wr_data_r;
  logic                    out_valid_r;
  logic                    out_pred_r;

  logic                    in_fire;
  logic                    s1_adv;
  idx_t                    rd_idx;
  ctr_t                    s1_ctr;
  ctr_t                    s1_new;
  logic [HISTORY_BITS:0]   hist_ext;
  logic [HISTORY_BITS-1:0] hist_nxt;
  logic                    mem_we;
  idx_t                    mem_wa;
  ctr_t                    mem_wd;

  // Handshake: the update stage moves when the output register is free or
  // being drained, and a new request enters whenever that stage can move.
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = init_done_r && (!s1_valid_r || s1_adv);
  assign in_fire      = in_chan.valid && in_chan.ready;

  // Table index: history above the low address bits.
  assign rd_idx = {hist_r, in_chan.branch_pc[PC_INDEX_BITS-1:0]};

  // History shifts right with the outcome entering at the top.
  assign hist_ext = {in_chan.branch_taken, hist_r};
  assign hist_nxt = hist_ext[HISTORY_BITS:1];

  // Counter of the request in the update stage, forwarded from the write
  // that landed on the same entry at the edge of its read.
  assign s1_ctr = (fwd_valid_r && (wr_idx_r == s1_idx_r)) ? wr_data_r : rd_data_r;
  assign s1_new = next_count(s1_ctr, s1_taken_r);

  // Write port: the clearing sweep, then the counter write-back.
  always_comb begin
    if (!init_done_r) begin
      mem_we = 1'b1;
      mem_wa = clr_idx_r;
      mem_wd = CTR_RESET;
    end else begin
      mem_we = s1_adv;
      mem_wa = s1_idx_r;
      mem_wd = s1_new;
    end
  end

  // Memory with registered read; a read and a write at the same edge return
  // the old contents.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r <= mem[rd_idx];
    end
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  // Clearing sweep after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_done_r <= 1'b0;
      clr_idx_r   <= '0;
    end else if (!init_done_r) begin
      clr_idx_r <= clr_idx_r + idx_t'(1);
      if (clr_idx_r == idx_t'(TABLE_DEPTH - 1)) begin
        init_done_r <= 1'b1;
      end
    end
  end

  // Global history.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '1;
    end else if (in_fire) begin
      hist_r <= hist_nxt;
    end
  end

  // Update stage and its forwarding register. The forwarding flag is taken
  // with each read, so it stays matched to the data while the stage stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r  <= 1'b1;
        fwd_valid_r <= s1_adv;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_idx_r   <= rd_idx;
      s1_taken_r <= in_chan.branch_taken;
    end
    if (s1_adv) begin
      wr_idx_r  <= s1_idx_r;
      wr_data_r <= s1_new;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_pred_r <= predicts_taken(s1_ctr);
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.predict_taken = out_pred_r;

`ifndef NO_ASSERTIONS
  // No request is taken while the memory is still being cleared.
  a_no_req_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done_r |-> !in_fire)
    else $error("request accepted during clearing sweep");

  // A stalled update stage keeps its entry and its forwarding choice.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_idx_r) && $stable(fwd_valid_r)))
    else $error("update stage lost its request while stalled");

  // Every accepted request occupies the update stage in the next cycle.
  a_fire_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_valid_r)
    else $error("accepted request did not reach the update stage");

  // Once the sweep is over, the memory is written only by a moving request.
  a_wb_only_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (init_done_r && mem_we) |-> s1_valid_r)
    else $error("counter write-back without a request");
`endif

endmodule
